@@ hw/rtl/qp_base64_encoded_text_decoder_assert.svh @@
// assertion macros used by the checker file of the encoded text decoder
`ifndef QP_BASE64_ENCODED_TEXT_DECODER_ASSERT_SVH
`define QP_BASE64_ENCODED_TEXT_DECODER_ASSERT_SVH

// same-cycle implication, clocked on clk and held off while arst_n is low
`define QPB_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qpb64d check failed");

// next-cycle implication, clocked on clk and held off while arst_n is low
`define QPB_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qpb64d check failed");

`endif

@@ hw/rtl/qpb64d_pkg.sv @@
// types, constants and character decode functions of the encoded text decoder
package qpb64d_pkg;

	localparam int COUNT_BITS_DEF = 16;
	localparam int OUT_COUNT_W    = 16;
	localparam int LETTER_W       = 8;
	localparam int APB_ADDR_W     = 3;
	localparam int APB_DATA_W     = 32;

	localparam logic [0:0] REG_ENCODING_LETTER = 1'b0;

	localparam logic [LETTER_W-1:0] LETTER_RESET = 8'h71;
	localparam logic [7:0] CASE_BIT = 8'h20;
	localparam logic [7:0] MODE_Q   = 8'h71;
	localparam logic [7:0] MODE_B   = 8'h62;

	localparam logic [7:0] CH_NUL        = 8'h00;
	localparam logic [7:0] CH_LF         = 8'h0a;
	localparam logic [7:0] CH_CR         = 8'h0d;
	localparam logic [7:0] CH_SPACE      = 8'h20;
	localparam logic [7:0] CH_PLUS       = 8'h2b;
	localparam logic [7:0] CH_SLASH      = 8'h2f;
	localparam logic [7:0] CH_EQ         = 8'h3d;
	localparam logic [7:0] CH_QMARK      = 8'h3f;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5f;

	localparam logic [5:0] B64_PLUS  = 6'd62;
	localparam logic [5:0] B64_SLASH = 6'd63;

	typedef enum logic [1:0] {
		PH_NORMAL = 2'd0,
		PH_EQ     = 2'd1,
		PH_HEX    = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_END  = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t                  kind;
		logic [7:0]             data;
		logic [OUT_COUNT_W-1:0] count;
	} result_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	typedef struct packed {
		logic       ok;
		logic [5:0] val;
	} six_t;

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t       r;
		logic [7:0] d;
		r = '0;
		d = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			d = c - 8'h30;
			r = '{ok: 1'b1, val: d[3:0]};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			d = c - 8'h57;
			r = '{ok: 1'b1, val: d[3:0]};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			d = c - 8'h37;
			r = '{ok: 1'b1, val: d[3:0]};
		end
		return r;
	endfunction

	function automatic six_t b64_decode(input logic [7:0] c);
		six_t       r;
		logic [7:0] d;
		r = '0;
		d = '0;
		if (c >= 8'h41 && c <= 8'h5a) begin
			d = c - 8'h41;
			r = '{ok: 1'b1, val: d[5:0]};
		end else if (c >= 8'h61 && c <= 8'h7a) begin
			d = c - 8'h47;
			r = '{ok: 1'b1, val: d[5:0]};
		end else if (c >= 8'h30 && c <= 8'h39) begin
			d = c + 8'h04;
			r = '{ok: 1'b1, val: d[5:0]};
		end else if (c == CH_PLUS) begin
			r = '{ok: 1'b1, val: B64_PLUS};
		end else if (c == CH_SLASH) begin
			r = '{ok: 1'b1, val: B64_SLASH};
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/qpb64d_regs.sv @@
// apb register file holding the encoding letter
module qpb64d_regs (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [qpb64d_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [qpb64d_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [qpb64d_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                  pready,
	output logic [qpb64d_pkg::LETTER_W-1:0]       letter
);

	logic [qpb64d_pkg::LETTER_W-1:0] letter_q;
	logic                            hit;
	logic                            wr_en;

	assign pready = 1'b1;
	assign hit    = (paddr[qpb64d_pkg::APB_ADDR_W-1:2] == qpb64d_pkg::REG_ENCODING_LETTER);
	assign wr_en  = psel && penable && pwrite && pready && hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			letter_q <= qpb64d_pkg::LETTER_RESET;
		end else if (wr_en) begin
			letter_q <= pwdata[qpb64d_pkg::LETTER_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (hit) begin
			prdata[qpb64d_pkg::LETTER_W-1:0] = letter_q;
		end
	end

	assign letter = letter_q;

endmodule

@@ hw/rtl/qpb64d_core.sv @@
// input register, running decode state and per-character decode logic
module qpb64d_core #(
	parameter int COUNT_BITS = qpb64d_pkg::COUNT_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        in_byte,
	input  logic                              first,
	input  logic [qpb64d_pkg::LETTER_W-1:0]   letter,
	output logic                              res_valid,
	input  logic                              res_ready,
	output qpb64d_pkg::result_t               result
);

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  first_s1;

	qpb64d_pkg::phase_t    phase_q;
	logic [3:0]            nib_q;
	logic [11:0]           pat_q;
	logic [3:0]            held_q;
	logic [COUNT_BITS-1:0] cnt_q;

	qpb64d_pkg::phase_t    ph;
	logic [3:0]            nib;
	logic [11:0]           pat;
	logic [3:0]            held;
	logic [COUNT_BITS-1:0] cnt;

	qpb64d_pkg::phase_t    n_ph;
	logic [3:0]            n_nib;
	logic [11:0]           n_pat;
	logic [3:0]            n_held;
	logic [COUNT_BITS-1:0] n_cnt;

	logic [COUNT_BITS-1:0] cnt_inc;
	logic [COUNT_BITS+15:0] cnt_ext;
	logic [15:0]           cnt_out;
	logic [7:0]            mode;
	logic                  term;
	qpb64d_pkg::hex_t      hx;
	qpb64d_pkg::six_t      sx;
	logic [11:0]           pat_new;
	logic [3:0]            held_new;
	logic [11:0]           shifted;
	logic                  emit;
	logic                  advance;

	// input register
	assign advance  = valid_s1 && (!emit || res_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1  <= in_byte;
			first_s1 <= first;
		end
	end

	// running state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= qpb64d_pkg::PH_NORMAL;
			nib_q   <= '0;
			pat_q   <= '0;
			held_q  <= '0;
			cnt_q   <= '0;
		end else if (advance) begin
			phase_q <= n_ph;
			nib_q   <= n_nib;
			pat_q   <= n_pat;
			held_q  <= n_held;
			cnt_q   <= n_cnt;
		end
	end

	// a first-flagged character starts from cleared state
	always_comb begin
		if (first_s1) begin
			ph   = qpb64d_pkg::PH_NORMAL;
			nib  = '0;
			pat  = '0;
			held = '0;
			cnt  = '0;
		end else begin
			ph   = phase_q;
			nib  = nib_q;
			pat  = pat_q;
			held = held_q;
			cnt  = cnt_q;
		end
	end

	assign cnt_inc  = (&cnt) ? cnt : cnt + COUNT_BITS'(1);
	assign cnt_ext  = {16'b0, cnt};
	assign cnt_out  = (|cnt_ext[COUNT_BITS+15:16]) ? 16'hffff : cnt_ext[15:0];
	assign mode     = letter | qpb64d_pkg::CASE_BIT;
	assign term     = (byte_s1 == qpb64d_pkg::CH_NUL) || (byte_s1 == qpb64d_pkg::CH_QMARK);
	assign hx       = qpb64d_pkg::hex_decode(byte_s1);
	assign sx       = qpb64d_pkg::b64_decode(byte_s1);
	assign pat_new  = {pat[5:0], sx.val};
	assign held_new = held + 4'd6;
	assign shifted  = pat_new >> (held_new - 4'd8);

	always_comb begin
		n_ph   = ph;
		n_nib  = nib;
		n_pat  = pat;
		n_held = held;
		n_cnt  = cnt;
		emit   = 1'b0;
		result = '{kind: qpb64d_pkg::KIND_DATA, data: 8'h00, count: 16'h0000};
		if (ph != qpb64d_pkg::PH_DONE) begin
			if (mode == qpb64d_pkg::MODE_Q) begin
				case (ph)
					qpb64d_pkg::PH_EQ: begin
						if (byte_s1 == qpb64d_pkg::CH_CR || byte_s1 == qpb64d_pkg::CH_LF) begin
							n_ph = qpb64d_pkg::PH_NORMAL;
						end else if (hx.ok) begin
							n_nib = hx.val;
							n_ph  = qpb64d_pkg::PH_HEX;
						end else begin
							emit        = 1'b1;
							n_ph        = qpb64d_pkg::PH_DONE;
							result.kind = qpb64d_pkg::KIND_ERR;
						end
					end
					qpb64d_pkg::PH_HEX: begin
						emit = 1'b1;
						if (hx.ok) begin
							n_ph        = qpb64d_pkg::PH_NORMAL;
							n_cnt       = cnt_inc;
							result.data = {nib, hx.val};
						end else begin
							n_ph        = qpb64d_pkg::PH_DONE;
							result.kind = qpb64d_pkg::KIND_ERR;
						end
					end
					default: begin
						if (term) begin
							emit         = 1'b1;
							n_ph         = qpb64d_pkg::PH_DONE;
							result.kind  = qpb64d_pkg::KIND_END;
							result.count = cnt_out;
						end else if (byte_s1 == qpb64d_pkg::CH_EQ) begin
							n_ph = qpb64d_pkg::PH_EQ;
						end else begin
							emit  = 1'b1;
							n_cnt = cnt_inc;
							if (byte_s1 == qpb64d_pkg::CH_UNDERSCORE) begin
								result.data = qpb64d_pkg::CH_SPACE;
							end else begin
								result.data = byte_s1;
							end
						end
					end
				endcase
			end else if (mode == qpb64d_pkg::MODE_B) begin
				n_ph = qpb64d_pkg::PH_NORMAL;
				if (term) begin
					emit         = 1'b1;
					n_ph         = qpb64d_pkg::PH_DONE;
					result.kind  = qpb64d_pkg::KIND_END;
					result.count = cnt_out;
				end else if (sx.ok) begin
					n_pat = pat_new;
					if (held_new >= 4'd8) begin
						emit        = 1'b1;
						n_held      = held_new - 4'd8;
						n_cnt       = cnt_inc;
						result.data = shifted[7:0];
					end else begin
						n_held = held_new;
					end
				end
			end else begin
				emit        = 1'b1;
				n_ph        = qpb64d_pkg::PH_DONE;
				result.kind = qpb64d_pkg::KIND_ERR;
			end
		end
	end

	assign res_valid = valid_s1 && emit;

endmodule

@@ hw/rtl/qpb64d_outreg.sv @@
// result register between the decode logic and the output channel
module qpb64d_outreg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      res_valid,
	output logic                      res_ready,
	input  qpb64d_pkg::result_t       result,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [1:0]                out_kind,
	output logic [7:0]                out_byte,
	output logic [qpb64d_pkg::OUT_COUNT_W-1:0] out_count
);

	logic                out_valid_q;
	qpb64d_pkg::result_t res_q;

	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			res_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = res_q.kind;
	assign out_byte  = res_q.data;
	assign out_count = res_q.count;

endmodule

@@ hw/rtl/qp_base64_encoded_text_decoder.sv @@
// top level of the quoted-printable / base64 encoded text decoder
// usage:
//   characters of one encoded word enter on the in channel (in_byte, first),
//   one transfer per character; first marks the opening character of a text
//   and clears the running state before that character is decoded.
//   each character gives zero or one transfer on the out channel: a data
//   byte, an end mark with the saturating byte count, or an error.
//   the apb port holds the encoding letter at address 0 (q or b, any case);
//   write it only while no character is in flight.
// path: a result passes the input register, then the result register, on its
//   way from its input transfer to out.
// throughput: one character per cycle while out_ready stays high, set by the
//   single decode stage between the input register and the result register.
// reset: arst_n clears the pipeline valids and the decode state; the letter
//   register returns to q.
// stall: while out_ready is low the result register holds; the decode stage
//   keeps taking characters that give no result, and in_ready drops once a
//   second result would need the register.
module qp_base64_encoded_text_decoder #(
	parameter int COUNT_BITS = qpb64d_pkg::COUNT_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [7:0]                            in_byte,
	input  logic                                  first,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [1:0]                            out_kind,
	output logic [7:0]                            out_byte,
	output logic [qpb64d_pkg::OUT_COUNT_W-1:0]    out_count,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [qpb64d_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [qpb64d_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [qpb64d_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                  pready
);

	logic [qpb64d_pkg::LETTER_W-1:0] letter;
	logic                            res_valid;
	logic                            res_ready;
	qpb64d_pkg::result_t             result;

	qpb64d_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.letter  (letter)
	);

	qpb64d_core #(
		.COUNT_BITS (COUNT_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.first     (first),
		.letter    (letter),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.result    (result)
	);

	qpb64d_outreg u_outreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.result    (result),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_kind  (out_kind),
		.out_byte  (out_byte),
		.out_count (out_count)
	);

endmodule

@@ hw/rtl/qpb64d_checker.sv @@
// port-level checker of the encoded text decoder and its bind
`include "qp_base64_encoded_text_decoder_assert.svh"

module qpb64d_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic [1:0]                         out_kind,
	input logic [7:0]                         out_byte,
	input logic [qpb64d_pkg::OUT_COUNT_W-1:0] out_count
);

	// a stalled result transfer keeps its payload
	`QPB_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_byte) && $stable(out_count))

	// data bytes carry no count
	`QPB_ASSERT_IMP(a_data_no_count, out_valid && out_kind == qpb64d_pkg::KIND_DATA, out_count == '0)

	// end and error marks carry no byte
	`QPB_ASSERT_IMP(a_mark_no_byte, out_valid && out_kind != qpb64d_pkg::KIND_DATA, out_byte == 8'h00)

	// errors carry no count
	`QPB_ASSERT_IMP(a_err_no_count, out_valid && out_kind == qpb64d_pkg::KIND_ERR, out_count == '0)

endmodule

bind qp_base64_encoded_text_decoder qpb64d_checker u_checker (.*);
